[rtl/hotp_pkg.sv]
// shared constants and helpers for the hotp hmac-sha1 validator
// no dependencies
package hotp_pkg;
  localparam int unsigned CODE_W = 20;
  localparam logic [31:0] OTP_MOD = 32'd1000000;
  // ceil(2^39 / 15625): quotient of (x >> 6) by 15625, exact for x below 2^31
  localparam logic [25:0] OTP_RECIP = 26'd35184373;
  localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                      32'h10325476, 32'hC3D2E1F0};
  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5c;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction
endpackage

[rtl/hotp_hmac_sha1_validator.sv]
// top level: hmac-sha1 hotp six-digit code check
// depends on hotp_pkg and hotp_sha1_core
//
// One word in, one word out. Each word runs four sha-1 compressions through a
// single round unit, each made of start, loading the 16 block words, 80 rounds,
// finish and handoff; then truncation, a reciprocal-multiply quotient and a
// subtraction that reduce modulo 1000000, and the output register. A new word is
// taken no earlier than the cycle after the previous result is taken. Key
// registers may be written while idle.
module hotp_hmac_sha1_validator import hotp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] counter_value,
  input  logic [CODE_W-1:0] candidate_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        code_valid,
  output logic [CODE_W-1:0] computed_code
);
  localparam logic IDX_UPPER = 1'b0;
  localparam logic IDX_LOWER = 1'b1;
  typedef enum logic [3:0] {S_IDLE, S_C0, S_C1, S_C2, S_C3, S_TRUNC, S_MOD, S_SUB,
                            S_OUT} state_t;
  state_t state;
  logic [15:0] key_upper;
  logic [63:0] key_lower;
  logic [63:0] msg;
  logic [CODE_W-1:0] cand;
  logic [159:0] ih, inner, hcur;
  logic [511:0] blk;
  logic start, busy_wait, done;
  logic [159:0] h_out;
  logic [31:0] bin, rem;
  logic [511:0] ipad_blk, opad_blk;
  logic [50:0] prod;
  logic [11:0] quo;
  logic [3:0] off;

  assign ipad_blk = {{key_upper, key_lower} ^ {10{IPAD}}, {54{IPAD}}};
  assign opad_blk = {{key_upper, key_lower} ^ {10{OPAD}}, {54{OPAD}}};
  hotp_sha1_core u_core (.clk, .rst, .start, .h_in(hcur), .blk, .done, .h_out);

  always_comb begin
    start = 1'b0; hcur = SHA1_IV; blk = ipad_blk;
    case (state)
      S_C0: begin start = !busy_wait; end
      S_C1: begin start = !busy_wait; hcur = ih;
        blk = {msg, 8'h80, 376'd0, 64'd576}; end
      S_C2: begin start = !busy_wait; blk = opad_blk; end
      S_C3: begin start = !busy_wait; hcur = ih;
        blk = {inner, 8'h80, 280'd0, 64'd672}; end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign off = h_out[3:0];
  assign prod = {26'd0, bin[30:6]} * {25'd0, OTP_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      busy_wait <= 1'b0;
      key_upper <= '0;
      key_lower <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          IDX_UPPER: key_upper <= cfg_data[15:0];
          IDX_LOWER: key_lower <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_valid) begin
          msg <= counter_value; cand <= candidate_code;
          busy_wait <= 1'b0; state <= S_C0;
        end
        S_C0, S_C1, S_C2, S_C3: begin
          if (start) busy_wait <= 1'b1;
          if (done) begin
            busy_wait <= 1'b0;
            case (state)
              S_C0: begin ih <= h_out; state <= S_C1; end
              S_C1: begin inner <= h_out; state <= S_C2; end
              S_C2: begin ih <= h_out; state <= S_C3; end
              default: state <= S_TRUNC;
            endcase
          end
        end
        S_TRUNC: begin
          bin <= {1'b0, h_out[159 - 8*off - 1 -: 31]};
          state <= S_MOD;
        end
        S_MOD: begin
          quo <= prod[50:39];
          state <= S_SUB;
        end
        S_SUB: begin
          rem <= bin - ({20'd0, quo} * OTP_MOD);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            computed_code <= rem[CODE_W-1:0];
            code_valid <= (rem[CODE_W-1:0] == cand);
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/hotp_sha1_core.sv]
// sha-1 compression of one 512-bit block, one round per cycle
// message schedule kept in a 16-entry ring memory; depends on hotp_pkg
module hotp_sha1_core import hotp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [159:0] h_in,
  input  logic [511:0] blk,
  output logic         done,
  output logic [159:0] h_out
);
  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_FIN} state_t;
  state_t state;
  logic [31:0] wmem [16];
  logic [6:0] rnd;
  logic [4:0] ld;
  logic [31:0] a, b, c, d, e;
  logic [159:0] hsave;
  logic [511:0] bsave;
  logic [31:0] w_cur, w_new, t;
  logic [3:0] ri;

  assign ri = rnd[3:0];
  assign w_new = {(wmem[ri + 4'd13] ^ wmem[ri + 4'd8] ^ wmem[ri + 4'd2] ^ wmem[ri]) << 1}
               | ((wmem[ri + 4'd13] ^ wmem[ri + 4'd8] ^ wmem[ri + 4'd2] ^ wmem[ri]) >> 31);
  assign w_cur = (rnd < 7'd16) ? wmem[ri] : w_new;
  assign t = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + round_k(rnd) + w_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          hsave <= h_in;
          bsave <= blk;
          {a, b, c, d, e} <= h_in;
          ld <= '0;
          state <= S_LOAD;
        end
        S_LOAD: begin
          wmem[ld[3:0]] <= bsave[511 - 32*ld[3:0] -: 32];
          ld <= ld + 5'd1;
          rnd <= '0;
          if (ld == 5'd15) state <= S_RUN;
        end
        S_RUN: begin
          if (rnd >= 7'd16) wmem[ri] <= w_new;
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= S_FIN;
        end
        S_FIN: begin
          h_out <= {hsave[159:128] + a, hsave[127:96] + b, hsave[95:64] + c,
                    hsave[63:32] + d, hsave[31:0] + e};
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// testbench for hotp_hmac_sha1_validator: hmac-sha1 six-digit code check
// holds its own hmac-sha1 and truncation predictor; depends on hotp_pkg and the rtl
module tb;
  import hotp_pkg::*;

  localparam int unsigned KEY_UPPER_IDX = 0;
  localparam int unsigned KEY_LOWER_IDX = 1;

  typedef struct packed {
    logic              match;
    logic [CODE_W-1:0] code;
  } otp_word_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [0:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [63:0] counter_value = '0;
  logic [CODE_W-1:0] candidate_code = '0;
  logic out_valid;
  logic out_stall = 0;
  logic code_valid;
  logic [CODE_W-1:0] computed_code;

  logic [15:0] key_hi = '0;
  logic [63:0] key_lo = '0;
  otp_word_t expected_codes[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int matches_seen = 0;
  int hold_rx = 0;
  bit quiet = 0;
  int stall_left = 0;

  hotp_hmac_sha1_validator dut (.*);

  always #2 clk = ~clk;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [159:0] sha1_round_block(input logic [159:0] h,
                                                    input logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    {a, b, c, d, e} = h;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  function automatic logic [CODE_W-1:0] hotp_code(input logic [15:0] khi,
                                                  input logic [63:0] klo,
                                                  input logic [63:0] factor);
    logic [511:0] ipad_blk, opad_blk, tail;
    logic [159:0] inner, dig;
    logic [3:0] off;
    logic [31:0] bin;
    ipad_blk = {{khi, klo} ^ {10{IPAD}}, {54{IPAD}}};
    opad_blk = {{khi, klo} ^ {10{OPAD}}, {54{OPAD}}};
    tail = {factor, 8'h80, 376'b0, 64'd576};
    inner = sha1_round_block(sha1_round_block(SHA1_IV, ipad_blk), tail);
    tail = {inner, 8'h80, 280'b0, 64'd672};
    dig = sha1_round_block(sha1_round_block(SHA1_IV, opad_blk), tail);
    off = dig[3:0];
    bin = dig[159 - 8*off -: 32] & 32'h7fffffff;
    return CODE_W'(bin % OTP_MOD);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 1);
    if (r < 19) return $urandom_range(2, 8);
    return $urandom_range(20, 90);
  endfunction

  task automatic write_key(input int unsigned idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx[0:0];
    cfg_data = data;
    @(negedge clk);
    cfg_we = 0;
    if (idx == KEY_UPPER_IDX) key_hi = data[15:0];
    else if (idx == KEY_LOWER_IDX) key_lo = data;
  endtask

  task automatic send_word(input logic [63:0] factor, input logic [CODE_W-1:0] cand,
                           input bit no_gap = 0);
    otp_word_t w;
    int gap;
    @(negedge clk);
    in_valid = 1;
    counter_value = factor;
    candidate_code = cand;
    do @(posedge clk); while (in_stall);
    w.code = hotp_code(key_hi, key_lo, factor);
    w.match = (w.code == cand);
    expected_codes.push_back(w);
    words_sent++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    wait (expected_codes.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_rx > 0) begin
      out_stall <= 1;
      hold_rx <= hold_rx - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 0;
      if (!quiet) begin
        if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 4);
        else if ($urandom_range(0, 99) == 0) stall_left <= $urandom_range(20, 150);
      end
    end
  end

  always @(posedge clk) begin
    otp_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        w = expected_codes.pop_front();
        words_checked++;
        if (code_valid) matches_seen++;
        if (computed_code !== w.code)
          report_mismatch($sformatf("computed_code %0d, expected %0d", computed_code, w.code));
        if (code_valid !== w.match)
          report_mismatch($sformatf("code_valid %b, expected %b", code_valid, w.match));
      end
    end
  end

  // send the word twice: once with a wrong candidate, once with the right one
  task automatic send_pair(input logic [63:0] factor);
    logic [CODE_W-1:0] c;
    c = hotp_code(key_hi, key_lo, factor);
    send_word(factor, (c == 0) ? CODE_W'(1) : CODE_W'(0));
    send_word(factor, c);
  endtask

  task automatic test_reset_key();
    send_word(64'd0, '0);
    send_word(64'hffff_ffff_ffff_ffff, CODE_W'(999999));
    send_word(64'd1, '1);
    send_pair(64'd0);
    send_pair(64'h8000_0000_0000_0000);
    drain();
  endtask

  task automatic test_key_extremes();
    write_key(KEY_UPPER_IDX, 64'hffff_ffff_ffff_ffff);
    write_key(KEY_LOWER_IDX, 64'hffff_ffff_ffff_ffff);
    send_pair(64'd0);
    send_pair(64'hffff_ffff_ffff_ffff);
    send_word(64'h5555_aaaa_5555_aaaa, '1);
    drain();
    write_key(KEY_UPPER_IDX, 64'h0001_0000_0000_8000);
    write_key(KEY_LOWER_IDX, 64'h0000_0000_0000_0001);
    send_pair(64'h0123_4567_89ab_cdef);
    send_word(64'd59, CODE_W'(999999));
    drain();
  endtask

  task automatic test_backpressure();
    hold_rx = 3000;
    repeat (6) send_word({$urandom, $urandom}, CODE_W'($urandom_range(0, 999999)), 1);
    drain();
  endtask

  task automatic test_random(input int count);
    logic [63:0] f;
    logic [CODE_W-1:0] c;
    int r;
    for (int p = 0; p < 5; p++) begin
      write_key(KEY_UPPER_IDX, {$urandom, $urandom});
      write_key(KEY_LOWER_IDX, {$urandom, $urandom});
      quiet = (p == 2);
      for (int i = 0; i < count / 5; i++) begin
        r = $urandom_range(0, 9);
        f = (r < 3) ? 64'($urandom_range(0, 1000)) : {$urandom, $urandom};
        r = $urandom_range(0, 9);
        if (r < 3) c = hotp_code(key_hi, key_lo, f);
        else if (r < 4) c = CODE_W'($urandom_range(1000000, 1048575));
        else c = CODE_W'($urandom_range(0, 999999));
        send_word(f, c);
      end
      quiet = 0;
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_reset_key();
    test_key_extremes();
    test_backpressure();
    test_random(650);
    repeat (50) @(posedge clk);
    $display("covered %0d words (%0d matching codes) over several keys, with stalls",
             words_checked, matches_seen);
    $display("and gaps on both sides, %0d mismatches", errors);
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end
endmodule

[hotp_hmac_sha1_validator.f]
rtl/hotp_pkg.sv
rtl/hotp_sha1_core.sv
rtl/hotp_hmac_sha1_validator.sv
bench/tb.sv
